>>> hw/rtl/hvd_pkg.sv
// hvd_pkg: shared types and constants for the haversine distance pipeline.
// No dependencies; imported by every hvd_* module and the top level.
package hvd_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int LANES        = 4;

    // angle lanes of the front end
    localparam int LANE_RA   = 0;   // |lat_a| in radians
    localparam int LANE_RB   = 1;   // |lat_b|
    localparam int LANE_HLAT = 2;   // |dlat/2|
    localparam int LANE_HLON = 3;   // |dlon/2|, folded into [0, pi/2]

    localparam int XY_W = 34;       // CORDIC x/y datapath
    localparam int Z_W  = 33;       // CORDIC angle accumulator

    typedef logic [28:0] t_mag;     // coordinate magnitude, Q20 degrees
    typedef logic [30:0] t_angle;   // Q30 radians, 0 .. pi/2
    typedef logic [30:0] t_q30;     // Q30 value, 0 .. 1.0

    typedef struct packed {
        logic en;       // pipeline advance
        logic valid;    // item present at module input
    } t_pipe_ctl;

    localparam logic signed [27:0] LAT_LIMIT = 28'sd94371840;
    localparam logic signed [28:0] LON_LIMIT = 29'sd188743680;

    localparam logic [30:0] RECIP_45  = 31'd1527099484; // ceil(2^36/45)
    localparam logic [25:0] K_DIV_45  = 26'd37480660;   // floor(HALF_PI/45)
    localparam logic [14:0] RECIP_SM  = 15'd18941;      // 13*ceil(2^16/45)

    localparam t_angle      HALF_PI_Q30 = 31'd1686629713;
    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam t_q30        ONE_Q30     = 31'h4000_0000;
    localparam logic [29:0] INV_GAIN    = 30'd652032874;
    localparam logic [12:0] EARTH_R_KM  = 13'd6371;

    localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

endpackage

>>> hw/rtl/hvd_angle_prep.sv
// hvd_angle_prep: clamp, differences and degree-to-radian scaling, 4 stages.
// Depends on hvd_pkg.
module hvd_angle_prep import hvd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pipe_ctl          i_ctl,
    input  logic signed [27:0] i_lat_a,
    input  logic signed [27:0] i_lat_b,
    input  logic signed [28:0] i_lon_a,
    input  logic signed [28:0] i_lon_b,
    output logic               o_valid,
    output t_angle             o_angle [LANES]
);

    logic [3:0] r_v;

    logic signed [27:0] w_la, w_lb;
    logic signed [28:0] w_oa, w_ob, w_dlat;
    logic signed [29:0] w_dlon;
    t_mag               w_mag [LANES];

    t_mag        r1_mag [LANES];
    t_mag        r2_mag [LANES];
    logic [23:0] r2_dq  [LANES];
    logic [54:0] r3_p   [LANES];
    logic [23:0] r3_dq  [LANES];
    logic [5:0]  r3_dr  [LANES];
    t_angle      r4_ang [LANES];

    always_comb begin
        w_la = (i_lat_a > LAT_LIMIT) ? LAT_LIMIT :
               (i_lat_a < -LAT_LIMIT) ? -LAT_LIMIT : i_lat_a;
        w_lb = (i_lat_b > LAT_LIMIT) ? LAT_LIMIT :
               (i_lat_b < -LAT_LIMIT) ? -LAT_LIMIT : i_lat_b;
        w_oa = (i_lon_a > LON_LIMIT) ? LON_LIMIT :
               (i_lon_a < -LON_LIMIT) ? -LON_LIMIT : i_lon_a;
        w_ob = (i_lon_b > LON_LIMIT) ? LON_LIMIT :
               (i_lon_b < -LON_LIMIT) ? -LON_LIMIT : i_lon_b;
        w_dlat = 29'(w_lb) - 29'(w_la);
        w_dlon = 30'(w_ob) - 30'(w_oa);
        w_mag[LANE_RA]   = t_mag'(w_la[27] ? -w_la : w_la);
        w_mag[LANE_RB]   = t_mag'(w_lb[27] ? -w_lb : w_lb);
        w_mag[LANE_HLAT] = t_mag'(w_dlat[28] ? -w_dlat : w_dlat);
        w_mag[LANE_HLON] = t_mag'(w_dlon[29] ? -w_dlon : w_dlon);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[2:0], i_ctl.valid};
        end
    end

    // mag * HALF_PI / (45 * 2^n): split HALF_PI = 45*K + 13 so that every
    // division by 45 stays on a narrow value
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        localparam int SHIFT = (l == LANE_RA || l == LANE_RB) ? 21 : 22;

        logic [59:0] w_recip;
        logic [28:0] w_m45;
        logic [20:0] w_fsm;
        logic [54:0] w_sum;
        logic [32:0] w_q;

        always_comb begin
            w_recip = 60'(r1_mag[l]) * 60'(RECIP_45);
            w_m45   = 29'(r2_dq[l]) * 29'd45;
            w_fsm   = 21'(r3_dr[l]) * 21'(RECIP_SM);
            w_sum   = r3_p[l] + 55'(r3_dq[l]) * 55'd13 + 55'(w_fsm[20:16]);
            w_q     = 33'(w_sum >> SHIFT);
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r1_mag[l] <= w_mag[l];
                r2_mag[l] <= r1_mag[l];
                r2_dq[l]  <= w_recip[59:36];
                r3_p[l]   <= 55'(r2_mag[l]) * 55'(K_DIV_45);
                r3_dq[l]  <= r2_dq[l];
                r3_dr[l]  <= 6'(r2_mag[l] - w_m45);
                if (l == LANE_HLON && w_q > 33'(HALF_PI_Q30)) begin
                    r4_ang[l] <= t_angle'(PI_Q30 - w_q);
                end else begin
                    r4_ang[l] <= t_angle'(w_q);
                end
            end
        end

        assign o_angle[l] = r4_ang[l];
    end

    assign o_valid = r_v[3];

endmodule

>>> hw/rtl/hvd_cordic_rot.sv
// hvd_cordic_rot: four-lane rotation-mode CORDIC, one iteration per stage.
// Depends on hvd_pkg.
module hvd_cordic_rot import hvd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pipe_ctl          i_ctl,
    input  t_angle             i_angle [LANES],
    output logic               o_valid,
    output t_q30               o_cos   [LANES],
    output logic signed [31:0] o_sin   [LANES]
);

    logic [CORDIC_STEPS-1:0] r_v;

    logic signed [XY_W-1:0] r_x [CORDIC_STEPS][LANES];
    logic signed [XY_W-1:0] r_y [CORDIC_STEPS][LANES];
    logic signed [Z_W-1:0]  r_z [CORDIC_STEPS][LANES];
    logic signed [XY_W-1:0] w_x [CORDIC_STEPS+1][LANES];
    logic signed [XY_W-1:0] w_y [CORDIC_STEPS+1][LANES];
    logic signed [Z_W-1:0]  w_z [CORDIC_STEPS+1][LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[CORDIC_STEPS-2:0], i_ctl.valid};
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign w_x[0][l] = $signed({4'b0, INV_GAIN});
        assign w_y[0][l] = '0;
        assign w_z[0][l] = $signed({2'b0, i_angle[l]});

        for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
            logic signed [Z_W-1:0] w_atan;
            assign w_atan = $signed({1'b0, ATAN_TABLE[s]});

            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    if (!w_z[s][l][Z_W-1]) begin
                        r_x[s][l] <= w_x[s][l] - (w_y[s][l] >>> s);
                        r_y[s][l] <= w_y[s][l] + (w_x[s][l] >>> s);
                        r_z[s][l] <= w_z[s][l] - w_atan;
                    end else begin
                        r_x[s][l] <= w_x[s][l] + (w_y[s][l] >>> s);
                        r_y[s][l] <= w_y[s][l] - (w_x[s][l] >>> s);
                        r_z[s][l] <= w_z[s][l] + w_atan;
                    end
                end
            end

            assign w_x[s+1][l] = r_x[s][l];
            assign w_y[s+1][l] = r_y[s][l];
            assign w_z[s+1][l] = r_z[s][l];
        end

        // final clamp: cos to [0, 1], sin to [-1, 1]
        always_comb begin
            if (w_x[CORDIC_STEPS][l] < 0) begin
                o_cos[l] = '0;
            end else if (w_x[CORDIC_STEPS][l] > $signed({3'b0, ONE_Q30})) begin
                o_cos[l] = ONE_Q30;
            end else begin
                o_cos[l] = t_q30'(w_x[CORDIC_STEPS][l]);
            end
            if (w_y[CORDIC_STEPS][l] > $signed({3'b0, ONE_Q30})) begin
                o_sin[l] = $signed({1'b0, ONE_Q30});
            end else if (w_y[CORDIC_STEPS][l] < -$signed({3'b0, ONE_Q30})) begin
                o_sin[l] = -$signed({1'b0, ONE_Q30});
            end else begin
                o_sin[l] = 32'(w_y[CORDIC_STEPS][l]);
            end
        end
    end

    assign o_valid = r_v[CORDIC_STEPS-1];

endmodule

>>> hw/rtl/hvd_haver_sum.sv
// hvd_haver_sum: forms a = sin^2(dlat/2) + cos.cos.sin^2(dlon/2) and 1 - a.
// Two stages; depends on hvd_pkg.
module hvd_haver_sum import hvd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pipe_ctl          i_ctl,
    input  t_q30               i_cos_a,
    input  t_q30               i_cos_b,
    input  logic signed [31:0] i_sin_hlat,
    input  logic signed [31:0] i_sin_hlon,
    output logic               o_valid,
    output t_q30               o_a,
    output t_q30               o_na
);

    logic [1:0]         r_v;
    t_q30               r_cl, r_shl, r_shn, r_a, r_na;
    logic [61:0]        w_cl, w_t;
    logic signed [63:0] w_sql, w_sqn;
    logic [31:0]        w_sum;
    t_q30               w_a;

    always_comb begin
        w_cl  = 62'(i_cos_a) * 62'(i_cos_b);
        w_sql = 64'(i_sin_hlat) * 64'(i_sin_hlat);
        w_sqn = 64'(i_sin_hlon) * 64'(i_sin_hlon);
        w_t   = 62'(r_cl) * 62'(r_shn);
        w_sum = 32'(r_shl) + 32'(w_t >> 30);
        w_a   = (w_sum > 32'(ONE_Q30)) ? ONE_Q30 : w_sum[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_cl  <= t_q30'(w_cl >> 30);
            r_shl <= t_q30'(w_sql >>> 30);
            r_shn <= t_q30'(w_sqn >>> 30);
            r_a   <= w_a;
            r_na  <= ONE_Q30 - w_a;
        end
    end

    assign o_valid = r_v[1];
    assign o_a     = r_a;
    assign o_na    = r_na;

endmodule

>>> hw/rtl/hvd_isqrt.sv
// hvd_isqrt: two-lane floor square root of (v << 30), one result bit per stage.
// Depends on hvd_pkg.
module hvd_isqrt import hvd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_q30      i_val  [2],
    output logic      o_valid,
    output t_q30      o_root [2]
);

    logic [SQRT_STEPS-1:0] r_v;

    logic [60:0] r_rem [SQRT_STEPS][2];
    t_q30        r_r   [SQRT_STEPS][2];
    logic [60:0] w_rem [SQRT_STEPS+1][2];
    t_q30        w_r   [SQRT_STEPS+1][2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[SQRT_STEPS-2:0], i_ctl.valid};
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        assign w_rem[0][l] = {i_val[l], 30'b0};
        assign w_r[0][l]   = '0;

        for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_bit
            localparam int B = SQRT_STEPS - 1 - k;
            logic [62:0] w_trial;

            // (r + 2^B)^2 - r^2
            assign w_trial = (63'(w_r[k][l]) << (B + 1)) + (63'(1) << (2 * B));

            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    if (63'(w_rem[k][l]) >= w_trial) begin
                        r_rem[k][l] <= 61'(63'(w_rem[k][l]) - w_trial);
                        r_r[k][l]   <= w_r[k][l] | (t_q30'(1) << B);
                    end else begin
                        r_rem[k][l] <= w_rem[k][l];
                        r_r[k][l]   <= w_r[k][l];
                    end
                end
            end

            assign w_rem[k+1][l] = r_rem[k][l];
            assign w_r[k+1][l]   = r_r[k][l];
        end

        assign o_root[l] = w_r[SQRT_STEPS][l];
    end

    assign o_valid = r_v[SQRT_STEPS-1];

endmodule

>>> hw/rtl/hvd_cordic_vec.sv
// hvd_cordic_vec: vectoring-mode CORDIC for atan2(y, x), one iteration per stage.
// Depends on hvd_pkg.
module hvd_cordic_vec import hvd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_q30      i_y,
    input  t_q30      i_x,
    output logic      o_valid,
    output t_angle    o_angle
);

    logic [CORDIC_STEPS-1:0] r_v;

    logic signed [XY_W-1:0] r_x [CORDIC_STEPS];
    logic signed [XY_W-1:0] r_y [CORDIC_STEPS];
    logic signed [Z_W-1:0]  r_z [CORDIC_STEPS];
    logic signed [XY_W-1:0] w_x [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] w_y [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  w_z [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ctl.en) begin
            r_v <= {r_v[CORDIC_STEPS-2:0], i_ctl.valid};
        end
    end

    assign w_x[0] = $signed({3'b0, i_x});
    assign w_y[0] = $signed({3'b0, i_y});
    assign w_z[0] = '0;

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
        logic signed [Z_W-1:0] w_atan;
        assign w_atan = $signed({1'b0, ATAN_TABLE[s]});

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                if (!w_y[s][XY_W-1]) begin
                    r_x[s] <= w_x[s] + (w_y[s] >>> s);
                    r_y[s] <= w_y[s] - (w_x[s] >>> s);
                    r_z[s] <= w_z[s] + w_atan;
                end else begin
                    r_x[s] <= w_x[s] - (w_y[s] >>> s);
                    r_y[s] <= w_y[s] + (w_x[s] >>> s);
                    r_z[s] <= w_z[s] - w_atan;
                end
            end
        end

        assign w_x[s+1] = r_x[s];
        assign w_y[s+1] = r_y[s];
        assign w_z[s+1] = r_z[s];
    end

    always_comb begin
        if (w_z[CORDIC_STEPS] < 0) begin
            o_angle = '0;
        end else if (w_z[CORDIC_STEPS] > $signed({2'b0, HALF_PI_Q30})) begin
            o_angle = HALF_PI_Q30;
        end else begin
            o_angle = t_angle'(w_z[CORDIC_STEPS]);
        end
    end

    assign o_valid = r_v[CORDIC_STEPS-1];

endmodule

>>> hw/rtl/haversine_distance_core.sv
// haversine_distance_core: great-circle distance of two lat/lon points.
// Accepts one item per cycle while the skid entry is empty.
// The pipeline depth is dominated by the two 30-step CORDIC pipelines and the 31-stage root.
// Whole pipeline advances on one enable; a two-entry output (register + skid)
// keeps the input open during a first output stall.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
module haversine_distance_core import hvd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [119:0] i_s_tdata,  // lat_a[27:0], lat_b[55:28], lon_a[84:56],
                                     // lon_b[113:85], zero fill [119:114]
    // master side
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [31:0]  o_m_tdata   // distance_km[30:0], zero fill [31]
);

    // ------------------------------------------------------------------
    // Pipeline enable: stalls only when the skid entry is occupied.
    // ------------------------------------------------------------------
    logic      w_en;
    t_pipe_ctl w_ctl_prep, w_ctl_rot, w_ctl_sum, w_ctl_sqrt, w_ctl_vec;

    logic      r_out_v, r_skid_v, r_dv;
    logic [30:0] r_out, r_skid, r_dist;

    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    // front end: clamp, half differences, radians
    logic   w_prep_v;
    t_angle w_ang [LANES];

    assign w_ctl_prep = '{en: w_en, valid: i_s_tvalid};

    hvd_angle_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_prep),
        .i_lat_a (i_s_tdata[27:0]),
        .i_lat_b (i_s_tdata[55:28]),
        .i_lon_a (i_s_tdata[84:56]),
        .i_lon_b (i_s_tdata[113:85]),
        .o_valid (w_prep_v),
        .o_angle (w_ang)
    );

    // sin/cos of the four angles in parallel lanes
    logic               w_rot_v;
    t_q30               w_cos [LANES];
    logic signed [31:0] w_sin [LANES];

    assign w_ctl_rot = '{en: w_en, valid: w_prep_v};

    hvd_cordic_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_rot),
        .i_angle (w_ang),
        .o_valid (w_rot_v),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // haversine term a and its complement
    logic w_sum_v;
    t_q30 w_a, w_na;

    assign w_ctl_sum = '{en: w_en, valid: w_rot_v};

    hvd_haver_sum u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl_sum),
        .i_cos_a    (w_cos[LANE_RA]),
        .i_cos_b    (w_cos[LANE_RB]),
        .i_sin_hlat (w_sin[LANE_HLAT]),
        .i_sin_hlon (w_sin[LANE_HLON]),
        .o_valid    (w_sum_v),
        .o_a        (w_a),
        .o_na       (w_na)
    );

    // sqrt(a) and sqrt(1-a)
    logic w_sqrt_v;
    t_q30 w_sq_in [2];
    t_q30 w_root  [2];

    assign w_ctl_sqrt = '{en: w_en, valid: w_sum_v};
    assign w_sq_in[0] = w_a;
    assign w_sq_in[1] = w_na;

    hvd_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_sqrt),
        .i_val   (w_sq_in),
        .o_valid (w_sqrt_v),
        .o_root  (w_root)
    );

    // central half-angle c/2 = atan2(sqrt(a), sqrt(1-a))
    logic   w_vec_v;
    t_angle w_c_half;

    assign w_ctl_vec = '{en: w_en, valid: w_sqrt_v};

    hvd_cordic_vec u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_vec),
        .i_y     (w_root[0]),
        .i_x     (w_root[1]),
        .o_valid (w_vec_v),
        .o_angle (w_c_half)
    );

    // distance = 2 * R * (c/2), Q30 -> Q16 with round half up
    logic [43:0] w_dprod;
    assign w_dprod = 44'(w_c_half) * 44'(EARTH_R_KM) + 44'd4096;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (w_en) begin
            r_dv <= w_vec_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dist <= w_dprod[43:13];
        end
    end

    // ------------------------------------------------------------------
    // Output register plus skid entry. The skid only fills when a result
    // arrives while the output item is held, and it closes the enable.
    // ------------------------------------------------------------------
    logic w_push, w_pop;
    assign w_push = w_en && r_dv;
    assign w_pop  = r_out_v && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_v || w_pop) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (!r_out_v || w_pop) begin
                r_out <= r_dist;
            end else begin
                r_skid <= r_dist;
            end
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {1'b0, r_out};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry holds an item with the output register empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_tready && r_dv))
        else $error("skid filled without a held output and an arriving result");

    a_last_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv && !w_en) |=> r_dv)
        else $error("final pipeline stage dropped an item during a stall");

endmodule
